// File: hw/rtl/cbp_pkg.sv
// Shared types, constants and helpers for the circle/box push-out resolver.
// Used by the controller, the datapath and the top level; depends on nothing.
package cbp_pkg;

  localparam int unsigned BoxDepth  = 64;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned IdxW      = $clog2(BoxDepth);
  localparam int unsigned NumW      = $clog2(BoxDepth + 1);
  localparam int unsigned BoxCountW = 7;
  localparam int unsigned PassW     = 4;
  localparam int unsigned SkinW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned StepW     = 6;

  localparam logic [63:0] CenterEpsSq =
    64'((65'd1 << (2 * FracBits)) / 65'd100000000);

  localparam logic [BoxCountW-1:0] BoxCountReset = '0;
  localparam logic [PassW-1:0]     PassLimitReset = 4'd4;
  localparam logic [SkinW-1:0]     SkinWidthReset = 16'd1311;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBoxCount  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPassLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSkinWidth = 2'd2;

  // input kinds
  localparam logic OpLoad    = 1'b0;
  localparam logic OpResolve = 1'b1;

  // datapath operations
  localparam logic [4:0] DpIdle      = 5'd0;
  localparam logic [4:0] DpWrite     = 5'd1;
  localparam logic [4:0] DpStart     = 5'd2;
  localparam logic [4:0] DpRead      = 5'd3;
  localparam logic [4:0] DpClamp     = 5'd4;
  localparam logic [4:0] DpSqAx      = 5'd5;
  localparam logic [4:0] DpSqAz      = 5'd6;
  localparam logic [4:0] DpSqSr      = 5'd7;
  localparam logic [4:0] DpSqrtInit  = 5'd8;
  localparam logic [4:0] DpSqrtStep  = 5'd9;
  localparam logic [4:0] DpMulX      = 5'd10;
  localparam logic [4:0] DpMulZ      = 5'd11;
  localparam logic [4:0] DpDivStep   = 5'd12;
  localparam logic [4:0] DpApplyX    = 5'd13;
  localparam logic [4:0] DpApplyZ    = 5'd14;
  localparam logic [4:0] DpInside    = 5'd15;
  localparam logic [4:0] DpResult    = 5'd16;

  typedef struct packed {
    logic [5:0]  box_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] far_x;
    logic [31:0] far_y;
    logic [31:0] far_z;
    logic [30:0] radius;
    logic [30:0] height;
  } cbp_item_t;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
  } cbp_box_t;

  typedef struct packed {
    logic [4:0]       op;
    logic [IdxW-1:0]  addr;
    logic [SkinW-1:0] skin;
  } cbp_cmd_t;

  typedef struct packed {
    logic y_hit;
    logic far;
    logic too_far;
    logic center;
  } cbp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: hw/rtl/cbp_ctrl.sv
// Controller of the resolver: configuration registers, box and pass walk,
// and the sequencing of the datapath's units. Depends on cbp_pkg.
module cbp_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cbp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_op_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  cbp_pkg::cbp_stat_t             stat_i,
  output cbp_pkg::cbp_cmd_t              cmd_o
);
  import cbp_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SRead   = 4'd1;
  localparam logic [3:0] SClamp  = 4'd2;
  localparam logic [3:0] SSqAx   = 4'd3;
  localparam logic [3:0] SSqAz   = 4'd4;
  localparam logic [3:0] SSqSr   = 4'd5;
  localparam logic [3:0] STest   = 4'd6;
  localparam logic [3:0] SInside = 4'd7;
  localparam logic [3:0] SSqrt   = 4'd8;
  localparam logic [3:0] SMulX   = 4'd9;
  localparam logic [3:0] SDivX   = 4'd10;
  localparam logic [3:0] SApplyX = 4'd11;
  localparam logic [3:0] SMulZ   = 4'd12;
  localparam logic [3:0] SDivZ   = 4'd13;
  localparam logic [3:0] SApplyZ = 4'd14;
  localparam logic [3:0] SNext   = 4'd15;
  // result hand-over shares the idle code space through a flag
  logic [3:0] state_q, state_d;
  logic done_q, done_d;

  logic [BoxCountW-1:0] count_q;
  logic [PassW-1:0]     limit_q;
  logic [SkinW-1:0]     skin_q;
  logic [NumW-1:0]      box_q, box_d;
  logic [PassW-1:0]     pass_q, pass_d;
  logic                 pushed_q, pushed_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 outv_q, outv_d;
  logic [NumW-1:0]      num_boxes;
  logic                 accept;
  logic [4:0]           op;

  assign num_boxes  = (int'(count_q) > BoxDepth) ? NumW'(BoxDepth) : NumW'(count_q);
  assign in_ready_o = (state_q == SIdle) && !done_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = outv_q;

  assign cmd_o.op   = op;
  assign cmd_o.addr = box_q[IdxW-1:0];
  assign cmd_o.skin = skin_q;

  always_comb begin
    state_d  = state_q;
    done_d   = done_q;
    box_d    = box_q;
    pass_d   = pass_q;
    pushed_d = pushed_q;
    step_d   = step_q;
    outv_d   = outv_q && !out_ready_i;
    op       = DpIdle;
    unique case (state_q)
      SIdle: begin
        if (done_q) begin
          // hold the result until the output register is free
          if (!outv_q || out_ready_i) begin
            op     = DpResult;
            outv_d = 1'b1;
            done_d = 1'b0;
          end
        end else if (accept) begin
          if (in_op_i == OpLoad) begin
            op = DpWrite;
          end else begin
            op       = DpStart;
            box_d    = '0;
            pass_d   = '0;
            pushed_d = 1'b0;
            if (num_boxes == '0 || limit_q == '0) begin
              done_d = 1'b1;
            end else begin
              state_d = SRead;
            end
          end
        end
      end
      SRead: begin
        op      = DpRead;
        state_d = SClamp;
      end
      SClamp: begin
        op      = DpClamp;
        state_d = SSqAx;
      end
      SSqAx: begin
        if (!stat_i.y_hit || stat_i.far) begin
          state_d = SNext;
        end else begin
          op      = DpSqAx;
          state_d = SSqAz;
        end
      end
      SSqAz: begin
        op      = DpSqAz;
        state_d = SSqSr;
      end
      SSqSr: begin
        op      = DpSqSr;
        state_d = STest;
      end
      STest: begin
        if (stat_i.too_far) begin
          state_d = SNext;
        end else begin
          pushed_d = 1'b1;
          if (stat_i.center) begin
            state_d = SInside;
          end else begin
            op      = DpSqrtInit;
            step_d  = '0;
            state_d = SSqrt;
          end
        end
      end
      SInside: begin
        op      = DpInside;
        state_d = SNext;
      end
      SSqrt: begin
        op     = DpSqrtStep;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SqrtSteps - 1)) begin
          state_d = SMulX;
        end
      end
      SMulX: begin
        op      = DpMulX;
        step_d  = '0;
        state_d = SDivX;
      end
      SDivX: begin
        op     = DpDivStep;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = SApplyX;
        end
      end
      SApplyX: begin
        op      = DpApplyX;
        state_d = SMulZ;
      end
      SMulZ: begin
        op      = DpMulZ;
        step_d  = '0;
        state_d = SDivZ;
      end
      SDivZ: begin
        op     = DpDivStep;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = SApplyZ;
        end
      end
      SApplyZ: begin
        op      = DpApplyZ;
        state_d = SNext;
      end
      SNext: begin
        if (box_q + 1'b1 == num_boxes) begin
          if (!pushed_q || pass_q + 1'b1 == limit_q) begin
            state_d = SIdle;
            done_d  = 1'b1;
          end else begin
            box_d    = '0;
            pass_d   = pass_q + 1'b1;
            pushed_d = 1'b0;
            state_d  = SRead;
          end
        end else begin
          box_d   = box_q + 1'b1;
          state_d = SRead;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      done_q   <= 1'b0;
      box_q    <= '0;
      pass_q   <= '0;
      pushed_q <= 1'b0;
      step_q   <= '0;
      outv_q   <= 1'b0;
      count_q  <= BoxCountReset;
      limit_q  <= PassLimitReset;
      skin_q   <= SkinWidthReset;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      box_q    <= box_d;
      pass_q   <= pass_d;
      pushed_q <= pushed_d;
      step_q   <= step_d;
      outv_q   <= outv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBoxCount:  count_q <= cfg_data_i[BoxCountW-1:0];
          CfgPassLimit: limit_q <= cfg_data_i[PassW-1:0];
          CfgSkinWidth: skin_q  <= cfg_data_i[SkinW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/cbp_dp.sv
// Datapath of the resolver: box table, clamp and overlap tests, shared
// multiplier, bit-pair square root and restoring divider. Depends on cbp_pkg.
module cbp_dp (
  input  logic               clk_i,
  input  cbp_pkg::cbp_cmd_t  cmd_i,
  input  cbp_pkg::cbp_item_t item_i,
  output cbp_pkg::cbp_stat_t stat_o,
  output logic [31:0]        res_x_o,
  output logic [31:0]        res_y_o,
  output logic [31:0]        res_z_o
);
  import cbp_pkg::*;

  cbp_box_t mem_q [BoxDepth];
  cbp_box_t rd_q;

  logic signed [31:0] x_q, y_q, z_q;
  logic [30:0]        rad_q, hgt_q;
  logic [32:0]        ax_q, az_q;
  logic               dxneg_q, dzneg_q;
  logic signed [32:0] tminx_q, tmaxx_q, tminz_q, tmaxz_q;
  logic               y_hit_q, far_q;
  logic [64:0]        acc_q;
  logic [63:0]        srsq_q;
  logic [63:0]        v_q, r_q, bit_q;
  logic [31:0]        f_q;
  logic [63:0]        nq_q;
  logic [31:0]        rem_q;
  logic [31:0]        res_x_q, res_y_q, res_z_q;

  logic [31:0]        sr;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;

  assign sr = {1'b0, rad_q} + 32'(cmd_i.skin);

  // shared multiplier operand selection
  always_comb begin
    mul_a = sr;
    mul_b = sr;
    case (cmd_i.op)
      DpSqAx: begin mul_a = ax_q[31:0]; mul_b = ax_q[31:0]; end
      DpSqAz: begin mul_a = az_q[31:0]; mul_b = az_q[31:0]; end
      DpMulX: begin mul_a = ax_q[31:0]; mul_b = sr - r_q[31:0]; end
      DpMulZ: begin mul_a = az_q[31:0]; mul_b = f_q; end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // clamp and overlap tests
  logic signed [31:0] cx, cz, clx, clz;
  logic signed [32:0] dx, dz, ytop;
  logic [32:0]        ax, az;
  always_comb begin
    cx  = x_q;
    cz  = z_q;
    clx = (cx > $signed(rd_q.max_x)) ? $signed(rd_q.max_x) : cx;
    clx = (clx < $signed(rd_q.min_x)) ? $signed(rd_q.min_x) : clx;
    clz = (cz > $signed(rd_q.max_z)) ? $signed(rd_q.max_z) : cz;
    clz = (clz < $signed(rd_q.min_z)) ? $signed(rd_q.min_z) : clz;
    dx  = 33'(cx) - 33'(clx);
    dz  = 33'(cz) - 33'(clz);
    ax  = dx[32] ? 33'(-dx) : 33'(dx);
    az  = dz[32] ? 33'(-dz) : 33'(dz);
    ytop = 33'(y_q) + $signed({2'b00, hgt_q});
  end

  // square root trial
  logic [63:0] trial;
  assign trial = r_q + bit_q;

  // divider trial
  logic [32:0] dtry;
  logic        dge;
  assign dtry = {rem_q, nq_q[63]};
  assign dge  = dtry >= {1'b0, r_q[31:0]};

  // push application
  logic signed [65:0] mag_s, sum_x, sum_z;
  assign mag_s = $signed({2'b00, nq_q});
  assign sum_x = 66'(x_q) + (dxneg_q ? -mag_s : mag_s);
  assign sum_z = 66'(z_q) + (dzneg_q ? -mag_s : mag_s);

  // nearest face for a centre inside the box
  logic signed [32:0] best;
  logic signed [34:0] face;
  logic signed [34:0] sr_s;
  logic signed [65:0] ins_x, ins_z;
  always_comb begin
    sr_s = $signed({3'b000, sr});
    best = tminx_q;
    if (tmaxx_q < best) best = tmaxx_q;
    if (tminz_q < best) best = tminz_q;
    if (tmaxz_q < best) best = tmaxz_q;
    ins_x = 66'(x_q);
    ins_z = 66'(z_q);
    if (best == tminx_q) begin
      face  = -(35'(tminx_q) + sr_s);
      ins_x = 66'(x_q) + 66'(face);
    end else if (best == tmaxx_q) begin
      face  = 35'(tmaxx_q) + sr_s;
      ins_x = 66'(x_q) + 66'(face);
    end else if (best == tminz_q) begin
      face  = -(35'(tminz_q) + sr_s);
      ins_z = 66'(z_q) + 66'(face);
    end else begin
      face  = 35'(tmaxz_q) + sr_s;
      ins_z = 66'(z_q) + 66'(face);
    end
  end

  // box table
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DpWrite && int'(item_i.box_index) < BoxDepth) begin
      mem_q[IdxW'(item_i.box_index)] <= '{min_x: item_i.pos_x, min_y: item_i.pos_y,
                                          min_z: item_i.pos_z, max_x: item_i.far_x,
                                          max_y: item_i.far_y, max_z: item_i.far_z};
    end
    if (cmd_i.op == DpRead) begin
      rd_q <= mem_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DpStart: begin
        x_q   <= item_i.pos_x;
        y_q   <= item_i.pos_y;
        z_q   <= item_i.pos_z;
        rad_q <= item_i.radius;
        hgt_q <= item_i.height;
      end
      DpClamp: begin
        ax_q    <= ax;
        az_q    <= az;
        dxneg_q <= dx[32];
        dzneg_q <= dz[32];
        far_q   <= (ax > {1'b0, sr}) || (az > {1'b0, sr});
        y_hit_q <= !((y_q >= $signed(rd_q.max_y)) || (ytop <= 33'($signed(rd_q.min_y))));
        tminx_q <= 33'(x_q) - 33'($signed(rd_q.min_x));
        tmaxx_q <= 33'($signed(rd_q.max_x)) - 33'(x_q);
        tminz_q <= 33'(z_q) - 33'($signed(rd_q.min_z));
        tmaxz_q <= 33'($signed(rd_q.max_z)) - 33'(z_q);
      end
      DpSqAx: acc_q  <= 65'(prod);
      DpSqAz: acc_q  <= acc_q + 65'(prod);
      DpSqSr: srsq_q <= prod;
      DpSqrtInit: begin
        v_q   <= acc_q[63:0];
        r_q   <= '0;
        bit_q <= 64'd1 << 62;
      end
      DpSqrtStep: begin
        if (v_q >= trial) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      DpMulX: begin
        f_q   <= sr - r_q[31:0];
        nq_q  <= prod;
        rem_q <= '0;
      end
      DpMulZ: begin
        nq_q  <= prod;
        rem_q <= '0;
      end
      DpDivStep: begin
        rem_q <= dge ? 32'(dtry - {1'b0, r_q[31:0]}) : dtry[31:0];
        nq_q  <= {nq_q[62:0], dge};
      end
      DpApplyX: x_q <= sat32(sum_x);
      DpApplyZ: z_q <= sat32(sum_z);
      DpInside: begin
        x_q <= sat32(ins_x);
        z_q <= sat32(ins_z);
      end
      DpResult: begin
        res_x_q <= x_q;
        res_y_q <= y_q;
        res_z_q <= z_q;
      end
      default: ;
    endcase
  end

  assign stat_o.y_hit   = y_hit_q;
  assign stat_o.far     = far_q;
  assign stat_o.too_far = acc_q > {1'b0, srsq_q};
  assign stat_o.center  = acc_q <= {1'b0, CenterEpsSq};

  assign res_x_o = res_x_q;
  assign res_y_o = res_y_q;
  assign res_z_o = res_z_q;

endmodule

// File: hw/rtl/circle_box_pushout_resolver.sv
// Top level of the circle/box push-out resolver: stream ports, controller
// and datapath. Depends on cbp_pkg, cbp_ctrl and cbp_dp.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid/tready           tuser op, tdata item fields
//   m_axis    out        tvalid/tready           tdata res_x, res_y, res_z
//   cfg       in         cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// A resolve walks the boxes for each pass. A box that misses in height or
// bounds, or whose squared distance is too large, is skipped; a centre
// inside is pushed to the nearest face; any other box is pushed through the
// square root (32 steps, one result bit each) and the two 64-step restoring
// divides. The walk holds s_axis_tready low; a finished result waits in the
// output register while loads go on.
// Reset returns control and configuration to their reset values; the box table is not cleared.
module circle_box_pushout_resolver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // box_index[5:0] pos_x[37:6] pos_y[69:38] pos_z[101:70] far_x[133:102]
  // far_y[165:134] far_z[197:166] radius[228:198] height[259:229], zero pad
  input  logic [263:0]                 s_axis_tdata,
  // op
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // res_x[31:0] res_y[63:32] res_z[95:64]
  output logic [95:0]                  m_axis_tdata
);
  import cbp_pkg::*;

  cbp_item_t item;
  cbp_cmd_t  cmd;
  cbp_stat_t stat;
  logic [31:0] res_x, res_y, res_z;

  assign item.box_index = s_axis_tdata[5:0];
  assign item.pos_x     = s_axis_tdata[37:6];
  assign item.pos_y     = s_axis_tdata[69:38];
  assign item.pos_z     = s_axis_tdata[101:70];
  assign item.far_x     = s_axis_tdata[133:102];
  assign item.far_y     = s_axis_tdata[165:134];
  assign item.far_z     = s_axis_tdata[197:166];
  assign item.radius    = s_axis_tdata[228:198];
  assign item.height    = s_axis_tdata[259:229];

  cbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cbp_dp u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .item_i  (item),
    .stat_o  (stat),
    .res_x_o (res_x),
    .res_y_o (res_y),
    .res_z_o (res_z)
  );

  assign m_axis_tdata = {res_z, res_y, res_x};

endmodule

// File: hw/rtl/cbp_checker.sv
// Port-level checks for the resolver, attached to the top level by bind.
// Depends only on the top level's ports.
module cbp_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a resolve blocks further input in the cycle after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input taken during a resolve");

  // a result never appears in the cycle after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result raised straight after an item");

  // no result during reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid in reset");

endmodule

bind circle_box_pushout_resolver cbp_port_checks u_cbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
